[rtl/core/sap_pkg.sv]
// sap_pkg: byte codes, attribute types, color tables and SGR code decode
// for the SGR attribute parser. No dependencies.
`default_nettype none

package sap_pkg;

    // Byte codes seen in the text stream
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CSI   = 8'h5B;
    localparam logic [7:0] CH_SGR   = 8'h6D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;

    // Parameter value saturates here so it matches no code
    localparam logic [9:0] VAL_MAX = 10'd1023;

    // Style bit positions
    localparam int STY_BOLD      = 0;
    localparam int STY_ITALIC    = 1;
    localparam int STY_UNDERLINE = 2;

    typedef struct packed {
        logic [31:0] fg;
        logic [31:0] bg;
        logic [2:0]  sty;
    } attr_t;

    // White foreground, transparent background, no styles
    localparam attr_t ATTR_DEFAULT = '{fg: 32'hFFFF_FFFF, bg: 32'h0000_0000, sty: 3'b000};

    // One result word
    typedef struct packed {
        logic [7:0] ch;
        attr_t      attr;
        logic       last;
    } cell_t;

    function automatic logic [31:0] normal_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'h0000_00FF;
            3'd1:    c = 32'h8000_00FF;
            3'd2:    c = 32'h0080_00FF;
            3'd3:    c = 32'h8080_00FF;
            3'd4:    c = 32'h0000_80FF;
            3'd5:    c = 32'h8000_80FF;
            3'd6:    c = 32'h0080_80FF;
            default: c = 32'hC0C0_C0FF;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] bright_color(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd0:    c = 32'h4040_40FF;
            3'd1:    c = 32'hFF00_00FF;
            3'd2:    c = 32'h00FF_00FF;
            3'd3:    c = 32'hFFFF_00FF;
            3'd4:    c = 32'h0000_FFFF;
            3'd5:    c = 32'hFF00_FFFF;
            3'd6:    c = 32'h00FF_FFFF;
            default: c = 32'hFFFF_FFFF;
        endcase
        return c;
    endfunction

    // Apply one SGR parameter value to a set of attributes
    function automatic attr_t apply_code(input attr_t a, input logic [9:0] v);
        attr_t       r;
        logic [9:0]  off30;
        logic [9:0]  off90;
        logic [9:0]  off40;
        logic [9:0]  off100;
        r      = a;
        off30  = v - 10'd30;
        off90  = v - 10'd90;
        off40  = v - 10'd40;
        off100 = v - 10'd100;
        if (v == 10'd1)
            r.sty[STY_BOLD] = 1'b1;
        else if (v == 10'd3)
            r.sty[STY_ITALIC] = 1'b1;
        else if (v == 10'd4)
            r.sty[STY_UNDERLINE] = 1'b1;
        else if (v == 10'd22)
            r.sty[STY_BOLD] = 1'b0;
        else if (v == 10'd23)
            r.sty[STY_ITALIC] = 1'b0;
        else if (v == 10'd24)
            r.sty[STY_UNDERLINE] = 1'b0;
        else if (v >= 10'd30 && v <= 10'd37)
            r.fg = a.sty[STY_BOLD] ? bright_color(off30[2:0]) : normal_color(off30[2:0]);
        else if (v >= 10'd90 && v <= 10'd97)
            r.fg = bright_color(off90[2:0]);
        else if (v >= 10'd40 && v <= 10'd47)
            r.bg = normal_color(off40[2:0]);
        else if (v >= 10'd100 && v <= 10'd107)
            r.bg = bright_color(off100[2:0]);
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sap_if.sv]
// sap_if: valid/ready channel interfaces of the SGR attribute parser:
// terminal bytes in, attributed characters out. No dependencies.
`default_nettype none

interface sap_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_line;

    modport source (output valid, output in_byte, output end_of_line, input ready);
    modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface sap_cell_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic [31:0] fg_rgba;
    logic [31:0] bg_rgba;
    logic        is_bold;
    logic        is_italic;
    logic        is_underline;
    logic        last_of_run;

    modport source (output valid, output out_char, output fg_rgba, output bg_rgba,
                    output is_bold, output is_italic, output is_underline,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input fg_rgba, input bg_rgba,
                    input is_bold, input is_italic, input is_underline,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[rtl/core/sgr_attribute_parser.sv]
// SGR attribute parser: decodes ESC [ ... m sequences in a terminal byte
// stream and tags every visible byte with its colors and styles.
// Channels: text (sink) carries in_byte and end_of_line; cells (source)
// carries one attributed character per word, last_of_run marking the final
// word caused by one text word. A text word causes zero, one or two words.
// Results enter the result queue when their text word is accepted.
// Throughput: one text word per cycle while text.ready is high; the parse
// state is updated in the accept cycle, so back-to-back bytes see each other's effects.
// Output rate is one cell word per cycle while cells.ready is high; the
// 4-entry result queue raises text.ready while it has room for two words,
// so stalled cells stall text only once three or more words are waiting.
// Reset: parser returns to text phase with default attributes (white on
// transparent, no styles) and the queue is emptied. end_of_line also returns
// all parse state to defaults after its byte is handled.
// Depends on sap_pkg and sap_if.
`default_nettype none

module sgr_attribute_parser
    import sap_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sap_text_if.sink        text,
    sap_cell_if.source      cells
);

    // Parse phases
    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_SEQ  = 2'd2;

    // Parser state
    logic [1:0] phase_reg, phase_next;
    logic [9:0] pval_reg, pval_next;
    logic       phas_reg, phas_next;
    logic       pfrz_reg, pfrz_next;
    logic [1:0] slen_reg, slen_next;
    logic       sfz_reg, sfz_next;
    attr_t      cur_reg, cur_next;
    attr_t      shadow_reg, shadow_next;

    // Result queue
    cell_t      fifo_mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    logic        accept;
    logic        pop;
    logic [7:0]  b;
    logic        is_digit;
    logic        is_other;
    logic [13:0] acc;
    attr_t       fin_attr;
    logic [1:0]  n_emit;
    logic [7:0]  e0_ch;
    logic [7:0]  e1_ch;
    logic [1:0]  wr_ptr_inc;

    assign accept = text.valid & text.ready;
    assign pop    = cells.valid & cells.ready;
    assign b      = text.in_byte;

    // Byte classes and decimal accumulate
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_other = (b == CH_SEMI) || (b == CH_QUEST) || (b == CH_EQ) ||
                      (b == CH_GT) || (b == CH_LT);
    assign acc      = {1'b0, pval_reg, 3'b000} + {3'b000, pval_reg, 1'b0} +
                      {10'd0, b[3:0]};

    // Shadow attributes after the open parameter is closed
    assign fin_attr = phas_reg ? apply_code(shadow_reg, pval_reg) : shadow_reg;

    // Next parser state and emitted characters
    always_comb
    begin
        phase_next  = phase_reg;
        pval_next   = pval_reg;
        phas_next   = phas_reg;
        pfrz_next   = pfrz_reg;
        slen_next   = slen_reg;
        sfz_next    = sfz_reg;
        cur_next    = cur_reg;
        shadow_next = shadow_reg;
        n_emit      = 2'd0;
        e0_ch       = b;
        e1_ch       = b;
        if (accept)
        begin
            case (phase_reg)
                PH_ESC:
                begin
                    if (b == CH_CSI)
                    begin
                        phase_next  = PH_SEQ;
                        pval_next   = '0;
                        phas_next   = 1'b0;
                        pfrz_next   = 1'b0;
                        slen_next   = '0;
                        sfz_next    = 1'b0;
                        shadow_next = cur_reg;
                    end
                    else
                    begin
                        // lone ESC goes out as a character
                        e0_ch  = CH_ESC;
                        n_emit = 2'd1;
                        if (b != CH_ESC)
                        begin
                            e1_ch      = b;
                            n_emit     = 2'd2;
                            phase_next = PH_TEXT;
                        end
                    end
                end
                PH_SEQ:
                begin
                    if (is_digit || is_other)
                    begin
                        if (slen_reg == 2'd0)
                            sfz_next = (b == CH_ZERO);
                        if (slen_reg != 2'd3)
                            slen_next = slen_reg + 2'd1;
                        if (is_digit)
                        begin
                            if (!pfrz_reg)
                            begin
                                pval_next = (acc > {4'd0, VAL_MAX}) ? VAL_MAX : acc[9:0];
                                phas_next = 1'b1;
                            end
                        end
                        else if (b == CH_SEMI)
                        begin
                            shadow_next = fin_attr;
                            pval_next   = '0;
                            phas_next   = 1'b0;
                            pfrz_next   = 1'b0;
                        end
                        else
                        begin
                            pfrz_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // command byte ends the sequence
                        if (b == CH_SGR)
                        begin
                            if (slen_reg == 2'd0 || (slen_reg == 2'd1 && sfz_reg))
                            begin
                                cur_next = ATTR_DEFAULT;
                            end
                            else
                            begin
                                shadow_next = fin_attr;
                                cur_next    = fin_attr;
                            end
                        end
                        pval_next  = '0;
                        phas_next  = 1'b0;
                        pfrz_next  = 1'b0;
                        phase_next = PH_TEXT;
                    end
                end
                default:
                begin
                    if (b == CH_ESC)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        phase_next = PH_TEXT;
                        e0_ch      = b;
                        n_emit     = 2'd1;
                    end
                end
            endcase

            // end of line: flush a pending ESC, then back to defaults
            if (text.end_of_line)
            begin
                if (phase_next == PH_ESC)
                begin
                    if (n_emit == 2'd0)
                    begin
                        e0_ch  = CH_ESC;
                        n_emit = 2'd1;
                    end
                    else
                    begin
                        e1_ch  = CH_ESC;
                        n_emit = 2'd2;
                    end
                end
                phase_next  = PH_TEXT;
                pval_next   = '0;
                phas_next   = 1'b0;
                pfrz_next   = 1'b0;
                slen_next   = '0;
                sfz_next    = 1'b0;
                cur_next    = ATTR_DEFAULT;
                shadow_next = ATTR_DEFAULT;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TEXT;
            pval_reg   <= '0;
            phas_reg   <= 1'b0;
            pfrz_reg   <= 1'b0;
            slen_reg   <= '0;
            sfz_reg    <= 1'b0;
            cur_reg    <= ATTR_DEFAULT;
            shadow_reg <= ATTR_DEFAULT;
        end
        else
        begin
            phase_reg  <= phase_next;
            pval_reg   <= pval_next;
            phas_reg   <= phas_next;
            pfrz_reg   <= pfrz_next;
            slen_reg   <= slen_next;
            sfz_reg    <= sfz_next;
            cur_reg    <= cur_next;
            shadow_reg <= shadow_next;
        end
    end

    // Queue pointers and fill count
    assign wr_ptr_inc  = wr_ptr_reg + 2'd1;
    assign wr_ptr_next = wr_ptr_reg + n_emit;
    assign rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
    assign count_next  = count_reg + {1'b0, n_emit} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; all words of one byte share the current attributes
    always_ff @(posedge clk)
    begin
        if (n_emit != 2'd0)
            fifo_mem[wr_ptr_reg] <= '{ch: e0_ch, attr: cur_reg, last: (n_emit == 2'd1)};
        if (n_emit == 2'd2)
            fifo_mem[wr_ptr_inc] <= '{ch: e1_ch, attr: cur_reg, last: 1'b1};
    end

    // Channel outputs
    assign text.ready         = (count_reg <= 3'd2);
    assign cells.valid        = (count_reg != 3'd0);
    assign cells.out_char     = fifo_mem[rd_ptr_reg].ch;
    assign cells.fg_rgba      = fifo_mem[rd_ptr_reg].attr.fg;
    assign cells.bg_rgba      = fifo_mem[rd_ptr_reg].attr.bg;
    assign cells.is_bold      = fifo_mem[rd_ptr_reg].attr.sty[STY_BOLD];
    assign cells.is_italic    = fifo_mem[rd_ptr_reg].attr.sty[STY_ITALIC];
    assign cells.is_underline = fifo_mem[rd_ptr_reg].attr.sty[STY_UNDERLINE];
    assign cells.last_of_run  = fifo_mem[rd_ptr_reg].last;

endmodule

`default_nettype wire
